// ----- sv/rmq_pkg.sv -----
// Shared types and constants for the rotation matrix to quaternion converter.
// No dependencies.
package rmq_pkg;
	localparam int FRAC_BITS = 14;
	localparam int EW = 16;
	localparam int NW = EW + 1;
	localparam int RW = EW + 1;
	localparam int QW = EW;
	localparam int SW = QW + 1;
	localparam int SQ_STEPS = (FRAC_BITS + RW + 1) / 2;
	localparam int DIV_STEPS = QW - 1;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X = 2'd1,
		BR_Y = 2'd2,
		BR_Z = 2'd3
	} branch_t;

	typedef struct packed {
		branch_t branch;
		logic [3:0][NW-1:0] num;
	} side_t;
endpackage

// ----- sv/rmq_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on rmq_pkg.
module rmq_sqrt (
	input logic clk,
	input logic arst_n,
	input logic in_vld,
	input logic [rmq_pkg::RW-1:0] rad,
	input rmq_pkg::side_t in_side,
	output logic out_vld,
	output logic [rmq_pkg::SQ_STEPS-1:0] root,
	output rmq_pkg::side_t out_side
);
	import rmq_pkg::*;
	localparam int VW = 2 * SQ_STEPS;
	localparam int MW = SQ_STEPS + 4;

	logic vld_s [SQ_STEPS+1];
	logic [VW-1:0] v_s [SQ_STEPS+1];
	logic [MW-1:0] rem_s [SQ_STEPS+1];
	logic [SQ_STEPS-1:0] res_s [SQ_STEPS+1];
	side_t side_s [SQ_STEPS+1];

	assign vld_s[0] = in_vld;
	assign v_s[0] = VW'({rad, FRAC_BITS'(0)});
	assign rem_s[0] = '0;
	assign res_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		logic [MW-1:0] sh;
		logic [MW-1:0] trial;
		logic ge;
		assign sh = {rem_s[k][MW-3:0], v_s[k][VW-1:VW-2]};
		assign trial = MW'({res_s[k], 2'b01});
		assign ge = sh >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			v_s[k+1] <= v_s[k] << 2;
			rem_s[k+1] <= ge ? sh - trial : sh;
			res_s[k+1] <= {res_s[k][SQ_STEPS-2:0], ge};
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_vld = vld_s[SQ_STEPS];
	assign root = res_s[SQ_STEPS];
	assign out_side = side_s[SQ_STEPS];
endmodule

// ----- sv/rmq_div.sv -----
// Pipelined four-lane restoring divider with saturation detection.
// Depends on rmq_pkg.
module rmq_div (
	input logic clk,
	input logic arst_n,
	input logic in_vld,
	input logic [rmq_pkg::SQ_STEPS-1:0] root,
	input rmq_pkg::side_t in_side,
	output logic out_vld,
	output logic [3:0][rmq_pkg::QW-1:0] quat,
	output rmq_pkg::branch_t branch,
	output logic degen
);
	import rmq_pkg::*;
	localparam int DW = NW + FRAC_BITS;
	localparam int L = DIV_STEPS;

	typedef struct packed {
		branch_t branch;
		logic degen;
		logic [SW-1:0] s;
		logic [SQ_STEPS-2:0] half;
		logic [3:0] neg;
		logic [3:0] ovf;
	} dside_t;

	logic vld_s [L+1];
	dside_t ds_s [L+1];
	logic [3:0][SW-1:0] p_s [L+1];
	logic [3:0][L-1:0] d_s [L+1];
	logic [3:0][L-1:0] q_s [L+1];

	logic [SW-1:0] s_in;
	assign s_in = SW'({root, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	for (genvar j = 0; j < 4; j++) begin : g_lane
		logic signed [NW-1:0] n;
		logic [NW-1:0] mag;
		logic [DW-1:0] dd;
		assign n = $signed(in_side.num[j]);
		assign mag = n[NW-1] ? NW'(-n) : NW'(n);
		assign dd = DW'({mag, FRAC_BITS'(0)});
		always_ff @(posedge clk) begin
			ds_s[0].neg[j] <= n[NW-1];
			ds_s[0].ovf[j] <= {1'b0, dd} >= {s_in, L'(0)};
			p_s[0][j] <= SW'(dd[DW-1:L]);
			d_s[0][j] <= dd[L-1:0];
			q_s[0][j] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		ds_s[0].branch <= in_side.branch;
		ds_s[0].degen <= root == '0;
		ds_s[0].s <= s_in;
		ds_s[0].half <= root[SQ_STEPS-1:1];
	end

	for (genvar k = 0; k < L; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		for (genvar j = 0; j < 4; j++) begin : g_l
			logic [SW:0] pp;
			logic ge;
			assign pp = {p_s[k][j], d_s[k][j][L-1]};
			assign ge = pp >= {1'b0, ds_s[k].s};
			always_ff @(posedge clk) begin
				p_s[k+1][j] <= ge ? SW'(pp - {1'b0, ds_s[k].s}) : SW'(pp);
				d_s[k+1][j] <= d_s[k][j] << 1;
				q_s[k+1][j] <= {q_s[k][j][L-2:0], ge};
			end
		end
		always_ff @(posedge clk) begin
			ds_s[k+1] <= ds_s[k];
		end
	end

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			if (ds_s[L].degen) begin
				quat[j] = '0;
			end else if (j == int'(ds_s[L].branch)) begin
				quat[j] = QW'(ds_s[L].half);
			end else if (ds_s[L].ovf[j]) begin
				quat[j] = ds_s[L].neg[j] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
			end else begin
				quat[j] = ds_s[L].neg[j] ? QW'(-{1'b0, q_s[L][j]}) : {1'b0, q_s[L][j]};
			end
		end
	end

	assign out_vld = vld_s[L];
	assign branch = ds_s[L].branch;
	assign degen = ds_s[L].degen;
endmodule

// ----- sv/rotation_matrix_to_quaternion.sv -----
// Top level: rotation matrix to quaternion by Shepperd's method.
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
//
// Channel   Signals                         Handshake
// request   m00..m22                        start, taken when busy is low
// result    quat_w..quat_z, branch_taken,   done, one cycle, no back pressure
//           degenerate
//
// One request may enter every clock cycle; busy is always low.
// A request passes 34 register stages: one setup stage, 16 square root stages
// (one root bit each), one divider setup stage, 15 divider stages and one
// output register. Reset clears only the valid bits of the pipeline.
module rotation_matrix_to_quaternion (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [15:0] m00,
	input logic signed [15:0] m01,
	input logic signed [15:0] m02,
	input logic signed [15:0] m10,
	input logic signed [15:0] m11,
	input logic signed [15:0] m12,
	input logic signed [15:0] m20,
	input logic signed [15:0] m21,
	input logic signed [15:0] m22,
	output logic done,
	output logic signed [15:0] quat_w,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z,
	output logic [1:0] branch_taken,
	output logic degenerate
);
	import rmq_pkg::*;
	localparam int TW = EW + 3;

	logic signed [TW-1:0] e00, e11, e22, trace, rad;
	side_t side;
	logic vld_s1;
	logic [RW-1:0] rad_s1;
	side_t side_s1;
	logic sq_vld;
	logic [SQ_STEPS-1:0] sq_root;
	side_t sq_side;
	logic dv_vld;
	logic [3:0][QW-1:0] dv_quat;
	branch_t dv_branch;
	logic dv_degen;

	assign busy = 1'b0;
	assign e00 = TW'(m00);
	assign e11 = TW'(m11);
	assign e22 = TW'(m22);
	assign trace = e00 + e11 + e22;

	always_comb begin
		side.num = '0;
		if (trace > 0) begin
			side.branch = BR_TRACE;
			rad = trace + TW'(1 << FRAC_BITS);
			side.num[1] = NW'(m21) - NW'(m12);
			side.num[2] = NW'(m02) - NW'(m20);
			side.num[3] = NW'(m10) - NW'(m01);
		end else if (m00 > m11 && m00 > m22) begin
			side.branch = BR_X;
			rad = TW'(1 << FRAC_BITS) + e00 - e11 - e22;
			side.num[0] = NW'(m21) - NW'(m12);
			side.num[2] = NW'(m01) + NW'(m10);
			side.num[3] = NW'(m02) + NW'(m20);
		end else if (m11 > m22) begin
			side.branch = BR_Y;
			rad = TW'(1 << FRAC_BITS) + e11 - e00 - e22;
			side.num[0] = NW'(m02) - NW'(m20);
			side.num[1] = NW'(m01) + NW'(m10);
			side.num[3] = NW'(m12) + NW'(m21);
		end else begin
			side.branch = BR_Z;
			rad = TW'(1 << FRAC_BITS) + e22 - e00 - e11;
			side.num[0] = NW'(m10) - NW'(m01);
			side.num[1] = NW'(m02) + NW'(m20);
			side.num[2] = NW'(m12) + NW'(m21);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		rad_s1 <= (rad > 0) ? rad[RW-1:0] : '0;
		side_s1 <= side;
	end

	rmq_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(vld_s1),
		.rad(rad_s1),
		.in_side(side_s1),
		.out_vld(sq_vld),
		.root(sq_root),
		.out_side(sq_side)
	);

	rmq_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(sq_vld),
		.root(sq_root),
		.in_side(sq_side),
		.out_vld(dv_vld),
		.quat(dv_quat),
		.branch(dv_branch),
		.degen(dv_degen)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		quat_w <= dv_quat[0];
		quat_x <= dv_quat[1];
		quat_y <= dv_quat[2];
		quat_z <= dv_quat[3];
		branch_taken <= dv_branch;
		degenerate <= dv_degen;
	end

`ifndef SYNTHESIS
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> quat_w == 0 && quat_x == 0 && quat_y == 0 && quat_z == 0)
		else $error("degenerate result with nonzero components");
	a_trace_nondegen: assert property (@(posedge clk) disable iff (!arst_n)
		done && branch_taken == BR_TRACE |-> !degenerate)
		else $error("positive trace branch reported degenerate");
	a_trace_w_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done && branch_taken == BR_TRACE |-> quat_w > 0)
		else $error("positive trace branch gave nonpositive w");
`endif
endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the rotation matrix to quaternion converter.
// Depends on rmq_pkg and rotation_matrix_to_quaternion; predicts each result
// with its own fixed-point model and checks every output field.
`timescale 1ns / 100ps

module tb;
	import rmq_pkg::*;

	typedef struct {
		logic signed [15:0] w, x, y, z;
		branch_t br;
		logic degen;
	} quat_t;

	localparam int IDLE_LIMIT = 2000;

	logic clk, arst_n, start, busy, done, degenerate;
	logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
	logic [1:0] branch_taken;

	quat_t expected_quats[$];
	int mismatches, requests_sent, results_seen, idle_cycles;
	int branch_hits[4];
	int degen_hits;
	bit timed_out;

	rotation_matrix_to_quaternion dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint floor_sqrt(longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic quat_t matrix_to_quat(logic signed [15:0] a [9]);
		longint e[9], tr, rad, root, s, one;
		longint n[4], q[4];
		quat_t res;
		int k;
		for (int i = 0; i < 9; i++) e[i] = a[i];
		one = 64'sd1 << FRAC_BITS;
		tr = e[0] + e[4] + e[8];
		if (tr > 0) begin
			res.br = BR_TRACE;
			rad = tr + one;
			n[1] = e[7] - e[5]; n[2] = e[2] - e[6]; n[3] = e[3] - e[1];
		end else if (e[0] > e[4] && e[0] > e[8]) begin
			res.br = BR_X;
			rad = one + e[0] - e[4] - e[8];
			n[0] = e[7] - e[5]; n[2] = e[1] + e[3]; n[3] = e[2] + e[6];
		end else if (e[4] > e[8]) begin
			res.br = BR_Y;
			rad = one + e[4] - e[0] - e[8];
			n[0] = e[2] - e[6]; n[1] = e[1] + e[3]; n[3] = e[5] + e[7];
		end else begin
			res.br = BR_Z;
			rad = one + e[8] - e[0] - e[4];
			n[0] = e[3] - e[1]; n[1] = e[2] + e[6]; n[2] = e[5] + e[7];
		end
		k = int'(res.br);
		if (rad < 0) rad = 0;
		root = floor_sqrt(rad << FRAC_BITS);
		s = 2 * root;
		res.degen = (s == 0);
		for (int i = 0; i < 4; i++) begin
			if (res.degen) q[i] = 0;
			else if (i == k) q[i] = root / 2;
			else q[i] = (n[i] * one) / s;
		end
		res.w = clamp16(q[0]); res.x = clamp16(q[1]);
		res.y = clamp16(q[2]); res.z = clamp16(q[3]);
		return res;
	endfunction

	task automatic send_matrix(logic signed [15:0] a [9]);
		quat_t p;
		if ($urandom_range(0, 7) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
			{a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8]};
		@(posedge clk);
		while (busy) @(posedge clk);
		p = matrix_to_quat(a);
		expected_quats.push_back(p);
		branch_hits[int'(p.br)]++;
		if (p.degen) degen_hits++;
		requests_sent++;
	endtask

	task automatic pause_sender();
		start <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_entry();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'($urandom_range(0, 16384));
			4: return -$signed({1'b0, 15'($urandom_range(0, 16384))});
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		logic signed [15:0] a [9];
		a = '{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384};
		send_matrix(a);
		a = '{16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, -16'sd16384};
		send_matrix(a);
		a = '{-16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, -16'sd16384};
		send_matrix(a);
		a = '{-16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, 16'sd16384};
		send_matrix(a);
		a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_matrix(a);
		a = '{-16'sd8000, 5, 7, 9, -16'sd8000, 11, 13, 15, -16'sd8000};
		send_matrix(a);
		a = '{0, 100, 200, 300, 0, 400, 500, 600, -16'sd5};
		send_matrix(a);
		a = '{-16'sd32768, 0, 0, 0, -16'sd32768, 0, 0, 0, -16'sd32768};
		send_matrix(a);
		a = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
			16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
		send_matrix(a);
		a = '{-16'sd32768, 16'sh7fff, 16'sh8000, 16'sh8000, -16'sd32768,
			16'sh7fff, 16'sh7fff, 16'sh8000, -16'sd32767};
		send_matrix(a);
		a = '{0, 16'sh7fff, 16'sh8000, 16'sh8000, -16'sd32768, 16'sh7fff,
			16'sh7fff, 16'sh8000, -16'sd32768};
		send_matrix(a);
		a = '{-16'sd1, 16'sh7fff, 16'sh7fff, 16'sh8000, -16'sd1, 16'sh7fff,
			16'sh8000, 16'sh8000, -16'sd32768};
		send_matrix(a);
		a = '{-16'sd32768, 16'sh8000, 16'sh8000, 16'sh8000, -16'sd32768,
			16'sh8000, 16'sh8000, 16'sh8000, 16'sd2};
		send_matrix(a);
		a = '{16'sd1, 16'sh5555, 16'shaaaa, 16'shaaaa, 0, 16'sh5555,
			16'sh5555, 16'shaaaa, -16'sd1};
		send_matrix(a);
		pause_sender();
	endtask

	task automatic test_rotations(int count);
		logic signed [15:0] a [9];
		real w, x, y, z, nrm;
		for (int i = 0; i < count; i++) begin
			w = $urandom_range(0, 2000) - 1000.0; x = $urandom_range(0, 2000) - 1000.0;
			y = $urandom_range(0, 2000) - 1000.0; z = $urandom_range(0, 2000) - 1000.0;
			nrm = $sqrt(w*w + x*x + y*y + z*z) + 1e-9;
			w /= nrm; x /= nrm; y /= nrm; z /= nrm;
			a[0] = 16'($rtoi(16384.0 * (1 - 2*(y*y + z*z))));
			a[1] = 16'($rtoi(16384.0 * 2*(x*y - z*w)));
			a[2] = 16'($rtoi(16384.0 * 2*(x*z + y*w)));
			a[3] = 16'($rtoi(16384.0 * 2*(x*y + z*w)));
			a[4] = 16'($rtoi(16384.0 * (1 - 2*(x*x + z*z))));
			a[5] = 16'($rtoi(16384.0 * 2*(y*z - x*w)));
			a[6] = 16'($rtoi(16384.0 * 2*(x*z - y*w)));
			a[7] = 16'($rtoi(16384.0 * 2*(y*z + x*w)));
			a[8] = 16'($rtoi(16384.0 * (1 - 2*(x*x + y*y))));
			if ($urandom_range(0, 9) == 0) a[$urandom_range(0, 8)] = 16'($urandom);
			send_matrix(a);
			if ($urandom_range(0, 15) == 0) pause_sender();
		end
		pause_sender();
	endtask

	task automatic test_random_entries(int count);
		logic signed [15:0] a [9];
		for (int i = 0; i < count; i++) begin
			foreach (a[j]) a[j] = rand_entry();
			send_matrix(a);
		end
		pause_sender();
	endtask

	always @(posedge clk) begin
		quat_t e;
		if (arst_n && done) begin
			results_seen++;
			if (expected_quats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result at %0t", $time);
			end else begin
				e = expected_quats.pop_front();
				if (quat_w !== e.w || quat_x !== e.x || quat_y !== e.y
						|| quat_z !== e.z || branch_taken !== e.br
						|| degenerate !== e.degen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch at %0t: expected w %0d x %0d y %0d z %0d br %0d dg %0d, got w %0d x %0d y %0d z %0d br %0d dg %0d",
							$time, e.w, e.x, e.y, e.z, e.br, e.degen, quat_w, quat_x,
							quat_y, quat_z, branch_taken, degenerate);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("Timeout after %0d idle cycles", IDLE_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
		mismatches = 0; requests_sent = 0; results_seen = 0;
		idle_cycles = 0; degen_hits = 0; timed_out = 0;
		branch_hits = '{0, 0, 0, 0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_rotations(500);
		test_random_entries(330);
		while (expected_quats.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Sent %0d matrices, checked %0d quaternions, %0d mismatches.",
			requests_sent, results_seen, mismatches);
		$display("Branches trace/x/y/z: %0d/%0d/%0d/%0d, degenerate: %0d.",
			branch_hits[0], branch_hits[1], branch_hits[2], branch_hits[3], degen_hits);
		if (mismatches == 0 && expected_quats.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// ----- files.f -----
sv/rmq_pkg.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion.sv
tb/sv/tb.sv
